// File: rtl/dsis_pkg.sv
// Shared types and constants for the zoned disk sector interleave sequencer.
package dsis_pkg;

  // Item selector codes.
  typedef enum logic [1:0] {
    CMD_SEEK = 2'd0,
    CMD_NEXT = 2'd1,
    CMD_SAVE = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IL_ZONE0  = 3'd0,
    REG_IL_ZONE1  = 3'd1,
    REG_IL_ZONE2  = 3'd2,
    REG_IL_ZONE3  = 3'd3,
    REG_SKEW_EN   = 3'd4,
    REG_SECRST_EN = 3'd5
  } reg_idx_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned MAP_BITS    = 24;

  // Zone boundaries (first track of each zone) and sectors per track.
  localparam logic [5:0] ZONE1_TRACK = 6'd18;
  localparam logic [5:0] ZONE2_TRACK = 6'd25;
  localparam logic [5:0] ZONE3_TRACK = 6'd31;
  localparam logic [4:0] ZONE0_SECTORS = 5'd21;
  localparam logic [4:0] ZONE1_SECTORS = 5'd19;
  localparam logic [4:0] ZONE2_SECTORS = 5'd18;
  localparam logic [4:0] ZONE3_SECTORS = 5'd17;

  // Directory track handling and skew.
  localparam logic [5:0] DIR_TRACK        = 6'd18;
  localparam logic [7:0] DIR_SKIP_SECTORS = 8'd2;
  localparam logic [7:0] SKEW_STEP        = 8'd2;
  localparam logic [5:0] SKEW_EXTRA_TRACK = 6'd19;
  localparam logic [7:0] SKEW_EXTRA       = 8'd8;

  localparam logic [4:0] IL_ZONE0_RESET = 5'd4;
  localparam logic [4:0] IL_ZONE1_RESET = 5'd3;
  localparam logic [4:0] IL_ZONE2_RESET = 5'd3;
  localparam logic [4:0] IL_ZONE3_RESET = 5'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] start_track;
    logic [4:0] start_sector;
    logic [4:0] start_count;
  } req_t;

  typedef struct packed {
    logic [5:0] track_out;
    logic [7:0] sector_out;
    logic [4:0] remaining_out;
    logic       track_ended;
  } rsp_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_STEP   = 8'b0000_0100,
    ST_SKIP   = 8'b0000_1000,
    ST_AFTER  = 8'b0001_0000,
    ST_NTRACK = 8'b0010_0000,
    ST_SKEW   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

endpackage

// File: rtl/disk_sector_interleave_sequencer.sv
// Zoned disk sector interleave sequencer: top level with its step sequencer.
//
// Usage: a request beat on req carries a command (seek, next block, next save
// block) and the seek start position. The block answers every request with
// exactly one beat on rsp giving the track and sector of the next block, the
// sectors still unused on the track and a track-ended flag. The cfg channel
// writes the interleave and skew controls; it is always ready and must only
// be used while the block is idle with no response outstanding.
// Flow: req_ready is high only in the idle state, so one request is worked
// on at a time. A next-block or save step marks the current sector used,
// advances by the interleave and, while sectors remain, skips used ones; a
// next-block step that empties the track, or finds it exhausted, then
// changes track, reloads the zone and applies the skew or sector reset. A
// seek loads the zone, then takes save-like steps until no more than the
// requested count is left. An unused selector, or a save step with nothing
// left, goes straight to the response. A single sector advance unit (add,
// wrap compare, subtract) is shared; the skip loop reuses it once per cycle.
// Reset puts the head on track 1, sector 0, zone 0, with an empty used map.
// The response sits in an output register; a new request is accepted while it
// waits, but the following response holds until rsp_ready takes the old one.
module disk_sector_interleave_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  dsis_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output dsis_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dsis_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dsis_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [4:0] interleave_zone0;
  logic [4:0] interleave_zone1;
  logic [4:0] interleave_zone2;
  logic [4:0] interleave_zone3;
  logic       skew_enable;
  logic       sector_reset_enable;

  // Head position and track state.
  logic [5:0]                   cur_track;
  logic [7:0]                   cur_sector;
  logic [4:0]                   zone_sectors;
  logic [4:0]                   zone_interleave;
  logic [dsis_pkg::MAP_BITS-1:0] used_map;
  logic [4:0]                   left_count;

  // Per-request registers.
  logic [1:0] cmd;
  logic [4:0] target;
  logic       ended;

  dsis_pkg::state_t state, state_next;

  logic       req_fire;
  logic       rsp_free;
  logic [7:0] adv_step;
  logic [7:0] adv_sum;
  logic [7:0] adv_wrap;
  logic [7:0] adv_result;
  logic       cur_in_map;
  logic       cur_used;
  logic [4:0] left_dec;
  logic [5:0] ntrack_inc;
  logic [5:0] ntrack;
  logic [7:0] ntrack_sector;
  logic [4:0] new_zone_sectors;
  logic [4:0] new_zone_interleave;
  logic [7:0] skew_a;
  logic [7:0] skew_b;
  logic [7:0] skew_sector;

  assign req_ready = (state == dsis_pkg::ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign cfg_ready = 1'b1;

  // Shared sector advance unit: the step is the interleave in STEP, else one.
  assign adv_step = (state == dsis_pkg::ST_STEP) ? {3'b000, zone_interleave} : 8'd1;
  assign adv_sum  = cur_sector + adv_step;

  always_comb begin
    adv_wrap = adv_sum - {3'b000, zone_sectors};
    if (adv_sum >= {3'b000, zone_sectors}) begin
      // Zone 0 tracks lose one extra sector position on wrap.
      if (cur_track < dsis_pkg::ZONE1_TRACK && adv_wrap != 8'd0) begin
        adv_result = adv_wrap - 8'd1;
      end else begin
        adv_result = adv_wrap;
      end
    end else begin
      adv_result = adv_sum;
    end
  end

  assign cur_in_map = (cur_sector < 8'(dsis_pkg::MAP_BITS));
  assign cur_used   = cur_in_map && used_map[cur_sector[4:0]];
  assign left_dec   = left_count - 5'd1;

  // Track change, stepping over the directory track.
  always_comb begin
    ntrack_inc    = cur_track + 6'd1;
    ntrack        = ntrack_inc;
    ntrack_sector = cur_sector;
    if (ntrack_inc == dsis_pkg::DIR_TRACK) begin
      ntrack        = ntrack_inc + 6'd1;
      ntrack_sector = cur_sector + dsis_pkg::DIR_SKIP_SECTORS;
    end
  end

  // Zone lookup for the current track.
  always_comb begin
    if (cur_track < dsis_pkg::ZONE1_TRACK) begin
      new_zone_sectors    = dsis_pkg::ZONE0_SECTORS;
      new_zone_interleave = interleave_zone0;
    end else if (cur_track < dsis_pkg::ZONE2_TRACK) begin
      new_zone_sectors    = dsis_pkg::ZONE1_SECTORS;
      new_zone_interleave = interleave_zone1;
    end else if (cur_track < dsis_pkg::ZONE3_TRACK) begin
      new_zone_sectors    = dsis_pkg::ZONE2_SECTORS;
      new_zone_interleave = interleave_zone2;
    end else begin
      new_zone_sectors    = dsis_pkg::ZONE3_SECTORS;
      new_zone_interleave = interleave_zone3;
    end
  end

  // Skew after a track change; an underflow wraps back into the track.
  always_comb begin
    skew_a = cur_sector - dsis_pkg::SKEW_STEP;
    skew_b = (cur_track == dsis_pkg::SKEW_EXTRA_TRACK) ? skew_a - dsis_pkg::SKEW_EXTRA
                                                       : skew_a;
    skew_sector = skew_b[7] ? skew_b + {3'b000, zone_sectors} : skew_b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dsis_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (req.cmd)
            dsis_pkg::CMD_SEEK: state_next = dsis_pkg::ST_LOAD;
            dsis_pkg::CMD_NEXT: state_next = (left_count != 5'd0) ? dsis_pkg::ST_STEP
                                                                  : dsis_pkg::ST_NTRACK;
            dsis_pkg::CMD_SAVE: state_next = (left_count != 5'd0) ? dsis_pkg::ST_STEP
                                                                  : dsis_pkg::ST_DONE;
            default:            state_next = dsis_pkg::ST_DONE;
          endcase
        end
      end
      dsis_pkg::ST_LOAD: begin
        state_next = (cmd == dsis_pkg::CMD_NEXT) ? dsis_pkg::ST_SKEW : dsis_pkg::ST_AFTER;
      end
      dsis_pkg::ST_STEP: begin
        state_next = (left_dec != 5'd0) ? dsis_pkg::ST_SKIP : dsis_pkg::ST_AFTER;
      end
      dsis_pkg::ST_SKIP: begin
        if (!cur_used) begin
          state_next = dsis_pkg::ST_AFTER;
        end
      end
      dsis_pkg::ST_AFTER: begin
        case (cmd)
          dsis_pkg::CMD_SEEK: state_next = (left_count > target) ? dsis_pkg::ST_STEP
                                                                 : dsis_pkg::ST_DONE;
          dsis_pkg::CMD_NEXT: state_next = (left_count == 5'd0) ? dsis_pkg::ST_NTRACK
                                                                : dsis_pkg::ST_DONE;
          default:            state_next = dsis_pkg::ST_DONE;
        endcase
      end
      dsis_pkg::ST_NTRACK: state_next = dsis_pkg::ST_LOAD;
      dsis_pkg::ST_SKEW:   state_next = dsis_pkg::ST_DONE;
      dsis_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = dsis_pkg::ST_IDLE;
        end
      end
      default: state_next = dsis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= dsis_pkg::ST_IDLE;
      interleave_zone0    <= dsis_pkg::IL_ZONE0_RESET;
      interleave_zone1    <= dsis_pkg::IL_ZONE1_RESET;
      interleave_zone2    <= dsis_pkg::IL_ZONE2_RESET;
      interleave_zone3    <= dsis_pkg::IL_ZONE3_RESET;
      skew_enable         <= 1'b0;
      sector_reset_enable <= 1'b0;
      cur_track           <= 6'd1;
      cur_sector          <= 8'd0;
      zone_sectors        <= dsis_pkg::ZONE0_SECTORS;
      zone_interleave     <= dsis_pkg::IL_ZONE0_RESET;
      used_map            <= '0;
      left_count          <= dsis_pkg::ZONE0_SECTORS;
      rsp_valid           <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dsis_pkg::REG_IL_ZONE0:  interleave_zone0    <= cfg_data;
          dsis_pkg::REG_IL_ZONE1:  interleave_zone1    <= cfg_data;
          dsis_pkg::REG_IL_ZONE2:  interleave_zone2    <= cfg_data;
          dsis_pkg::REG_IL_ZONE3:  interleave_zone3    <= cfg_data;
          dsis_pkg::REG_SKEW_EN:   skew_enable         <= cfg_data[0];
          dsis_pkg::REG_SECRST_EN: sector_reset_enable <= cfg_data[0];
          default: ;
        endcase
      end

      // A new beat loads when the output register is free; otherwise a taken
      // beat empties it.
      if (state == dsis_pkg::ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        dsis_pkg::ST_IDLE: begin
          if (req_fire && req.cmd == dsis_pkg::CMD_SEEK) begin
            cur_track  <= req.start_track;
            cur_sector <= {3'b000, req.start_sector};
          end
        end
        dsis_pkg::ST_LOAD: begin
          zone_sectors    <= new_zone_sectors;
          zone_interleave <= new_zone_interleave;
          left_count      <= new_zone_sectors;
          used_map        <= '0;
        end
        dsis_pkg::ST_STEP: begin
          if (cur_in_map) begin
            used_map[cur_sector[4:0]] <= 1'b1;
          end
          left_count <= left_dec;
          // With skew on, the last sector of a track is kept for the skew.
          if (left_dec != 5'd0 || !skew_enable) begin
            cur_sector <= adv_result;
          end
        end
        dsis_pkg::ST_SKIP: begin
          if (cur_used) begin
            cur_sector <= adv_result;
          end
        end
        dsis_pkg::ST_NTRACK: begin
          cur_track  <= ntrack;
          cur_sector <= ntrack_sector;
        end
        dsis_pkg::ST_SKEW: begin
          if (skew_enable) begin
            cur_sector <= skew_sector;
          end else if (sector_reset_enable) begin
            cur_sector <= 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-request and response payload registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd    <= req.cmd;
      target <= req.start_count;
      ended  <= 1'b0;
    end else if (state == dsis_pkg::ST_NTRACK) begin
      ended <= 1'b1;
    end else if (state == dsis_pkg::ST_AFTER && cmd == dsis_pkg::CMD_SAVE) begin
      ended <= (left_count == 5'd0);
    end

    if (state == dsis_pkg::ST_DONE && rsp_free) begin
      rsp.track_out     <= cur_track;
      rsp.sector_out    <= cur_sector;
      rsp.remaining_out <= left_count;
      rsp.track_ended   <= ended;
    end
  end

  // The count of unused sectors never exceeds the sectors on the track.
  assert property (@(posedge clk) disable iff (rst) left_count <= zone_sectors)
    else $error("left_count exceeds zone_sectors");

  // The skip loop only runs while sectors remain on the track.
  assert property (@(posedge clk) disable iff (rst)
    (state == dsis_pkg::ST_SKIP) |-> (left_count != 5'd0))
    else $error("skip loop entered with no sectors left");

  // A track change never lands on the directory track.
  assert property (@(posedge clk) disable iff (rst)
    (state == dsis_pkg::ST_LOAD && cmd == dsis_pkg::CMD_NEXT)
      |-> (cur_track != dsis_pkg::DIR_TRACK))
    else $error("track change landed on the directory track");

  // A seek never reports a finished track.
  assert property (@(posedge clk) disable iff (rst)
    (state == dsis_pkg::ST_DONE && cmd == dsis_pkg::CMD_SEEK) |-> !ended)
    else $error("seek reported track_ended");

  // An accepted seek loads the zone in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.cmd == dsis_pkg::CMD_SEEK) |=> (state == dsis_pkg::ST_LOAD))
    else $error("seek did not load the zone");

endmodule

// File: tb/dsis_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the sector sequencer's response beats.
package dsis_tb_pkg;
  import dsis_pkg::*;

  // Selector value with no command assigned to it.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  class sector_scoreboard;
    logic [4:0] il_reg [4];
    bit skew_on;
    bit restart_on;

    logic [5:0] track;
    logic [7:0] sector;
    logic [4:0] zone_len;
    logic [4:0] zone_il;
    logic [4:0] left;
    logic [MAP_BITS-1:0] used;

    rsp_t pending_pos [$];
    int mismatches;

    function new();
      il_reg[0] = IL_ZONE0_RESET;
      il_reg[1] = IL_ZONE1_RESET;
      il_reg[2] = IL_ZONE2_RESET;
      il_reg[3] = IL_ZONE3_RESET;
      skew_on = 1'b0;
      restart_on = 1'b0;
      track = 6'd1;
      sector = '0;
      zone_len = ZONE0_SECTORS;
      zone_il = il_reg[0];
      used = '0;
      left = ZONE0_SECTORS;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [4:0] data);
      case (idx)
        REG_IL_ZONE0, REG_IL_ZONE1, REG_IL_ZONE2, REG_IL_ZONE3: il_reg[idx[1:0]] = data;
        REG_SKEW_EN: skew_on = data[0];
        REG_SECRST_EN: restart_on = data[0];
        default: ;
      endcase
    endfunction

    // Sectors past the end of the map are never recorded and always count as free.
    function bit taken(logic [7:0] s);
      if (s >= MAP_BITS) return 1'b0;
      return used[s[4:0]];
    endfunction

    function void advance(logic [7:0] step);
      logic [7:0] s;
      s = sector + step;
      if (s >= {3'b0, zone_len}) begin
        s = s - {3'b0, zone_len};
        // The inner zone loses one extra sector on the wrap.
        if (track < ZONE1_TRACK && s != 8'd0) s = s - 8'd1;
      end
      sector = s;
    endfunction

    function void consume();
      if (sector < MAP_BITS) used[sector[4:0]] = 1'b1;
      left = left - 5'd1;
      if (left != 5'd0 || !skew_on) advance({3'b0, zone_il});
      if (left != 5'd0) begin
        while (taken(sector)) advance(8'd1);
      end
    endfunction

    function void load_zone();
      if (track < ZONE1_TRACK) begin
        zone_len = ZONE0_SECTORS;
        zone_il = il_reg[0];
      end else if (track < ZONE2_TRACK) begin
        zone_len = ZONE1_SECTORS;
        zone_il = il_reg[1];
      end else if (track < ZONE3_TRACK) begin
        zone_len = ZONE2_SECTORS;
        zone_il = il_reg[2];
      end else begin
        zone_len = ZONE3_SECTORS;
        zone_il = il_reg[3];
      end
      left = zone_len;
      used = '0;
    endfunction

    function void change_track();
      do begin
        track = track + 6'd1;
        if (track == DIR_TRACK) sector = sector + DIR_SKIP_SECTORS;
      end while (track == DIR_TRACK);
      load_zone();
      if (skew_on) begin
        sector = sector - SKEW_STEP;
        if (track == SKEW_EXTRA_TRACK) sector = sector - SKEW_EXTRA;
        // A negative sector folds back into the track.
        if (sector[7]) sector = sector + {3'b0, zone_len};
      end else if (restart_on) begin
        sector = '0;
      end
    endfunction

    function void accept_req(req_t r);
      rsp_t e;
      bit ended;
      ended = 1'b0;
      case (r.cmd)
        CMD_SEEK: begin
          track = r.start_track;
          sector = {3'b0, r.start_sector};
          load_zone();
          while (left > r.start_count) consume();
        end
        CMD_NEXT: begin
          if (left != 5'd0) consume();
          if (left == 5'd0) begin
            change_track();
            ended = 1'b1;
          end
        end
        CMD_SAVE: begin
          if (left != 5'd0) begin
            consume();
            ended = (left == 5'd0);
          end
        end
        default: ;
      endcase
      e.track_out = track;
      e.sector_out = sector;
      e.remaining_out = left;
      e.track_ended = ended;
      pending_pos.push_back(e);
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (pending_pos.size() == 0) begin
        $error("response beat with no request outstanding: %p", got);
        mismatches++;
        return;
      end
      want = pending_pos.pop_front();
      if (got.track_out !== want.track_out) begin
        $error("track_out: expected %0d, actual %0d", want.track_out, got.track_out);
        mismatches++;
      end
      if (got.sector_out !== want.sector_out) begin
        $error("sector_out: expected %0d, actual %0d", want.sector_out, got.sector_out);
        mismatches++;
      end
      if (got.remaining_out !== want.remaining_out) begin
        $error("remaining_out: expected %0d, actual %0d", want.remaining_out,
               got.remaining_out);
        mismatches++;
      end
      if (got.track_ended !== want.track_ended) begin
        $error("track_ended: expected %0d, actual %0d", want.track_ended, got.track_ended);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_pos.size();
    endfunction
  endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top-level testbench for the zoned disk sector interleave sequencer.
module tb;
  import dsis_pkg::*;
  import dsis_tb_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sector_scoreboard sb;
  bit calm = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  disk_sector_interleave_sequencer u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function bit take_break();
    return !calm && ($urandom_range(99) < 31);
  endfunction

  function req_t mk(logic [1:0] c, logic [5:0] t, logic [4:0] s, logic [4:0] n);
    req_t r;
    r.cmd = c;
    r.start_track = t;
    r.start_sector = s;
    r.start_count = n;
    return r;
  endfunction

  function req_t rand_item(logic [1:0] c);
    return mk(c, 6'($urandom_range(40, 1)), 5'($urandom_range(20, 0)),
              5'($urandom_range(21, 0)));
  endfunction

  task drive_req(req_t r);
    @(negedge clk);
    while (take_break()) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.accept_req(r);
  endtask

  task write_reg(reg_idx_t idx, logic [4:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task program_regs(logic [3:0][4:0] ils, bit skew, bit restart);
    for (int i = 0; i < 4; i++) write_reg(reg_idx_t'(i), ils[i]);
    write_reg(REG_SKEW_EN, {4'b0, skew});
    write_reg(REG_SECRST_EN, {4'b0, restart});
  endtask

  // Drops valid right after the last beat, then waits for every response.
  task wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Seeks followed by runs of mostly next-block and save steps, with some noise.
  task read_sessions(int n);
    int done_cnt;
    int run_len;
    int roll;
    done_cnt = 0;
    while (done_cnt < n) begin
      drive_req(rand_item(CMD_SEEK));
      done_cnt++;
      run_len = $urandom_range(45, 1);
      repeat (run_len) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          drive_req(rand_item(CMD_NEXT));
          done_cnt++;
        end else if (roll < 90) begin
          drive_req(rand_item(CMD_SAVE));
          done_cnt++;
        end else if (roll < 95) begin
          drive_req(rand_item(CMD_SPARE));
        end else begin
          drive_req(rand_item(CMD_SEEK));
          done_cnt++;
        end
      end
    end
  endtask

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_rsp(rsp);
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("disk_sector_interleave_sequencer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [3:0][4:0] ils;
    bit skew;
    bit restart;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: steps straight out of reset, the spare selector, empty
    // tracks, sectors past the zone end and the crossing of the directory track.
    drive_req(mk(CMD_NEXT, 6'd40, 5'd20, 5'd21));
    drive_req(mk(CMD_SPARE, 6'd40, 5'd20, 5'd21));
    drive_req(mk(CMD_SAVE, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_SEEK, 6'd1, 5'd0, 5'd21));
    drive_req(mk(CMD_SEEK, 6'd40, 5'd20, 5'd0));
    drive_req(mk(CMD_SAVE, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_NEXT, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_SEEK, 6'd17, 5'd20, 5'd1));
    drive_req(mk(CMD_SAVE, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_SAVE, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_NEXT, 6'd1, 5'd0, 5'd0));
    wait_drained();

    // Interleave 1 with skew: each track ends on sector 0, so the skew goes
    // negative, once on a plain track and once landing on track 19.
    program_regs({4{5'd1}}, 1'b1, 1'b0);
    drive_req(mk(CMD_SEEK, 6'd31, 5'd1, 5'd0));
    drive_req(mk(CMD_NEXT, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_SEEK, 6'd17, 5'd1, 5'd0));
    drive_req(mk(CMD_NEXT, 6'd1, 5'd0, 5'd0));
    wait_drained();

    program_regs({4{5'd16}}, 1'b0, 1'b1);
    drive_req(mk(CMD_SEEK, 6'd17, 5'd5, 5'd0));
    drive_req(mk(CMD_NEXT, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_NEXT, 6'd1, 5'd0, 5'd0));
    drive_req(mk(CMD_SEEK, 6'd35, 5'd0, 5'd4));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 4; i++) ils[i] = 5'($urandom_range(16, 1));
      skew = 1'($urandom_range(1));
      restart = 1'($urandom_range(1));
      if (p == 0) begin
        ils = {4{5'd16}};
        skew = 1'b0;
        restart = 1'b0;
      end else if (p == 1) begin
        ils = {4{5'd1}};
        skew = 1'b1;
        restart = 1'b1;
      end
      program_regs(ils, skew, restart);
      calm = (p == 2);
      if (p == 3) begin
        // One long read from the outer track on, far enough for the track
        // counter to wrap past 63 and come back into the inner zone.
        drive_req(mk(CMD_SEEK, 6'd40, 5'($urandom_range(20, 0)), 5'd0));
        repeat (460) begin
          if ($urandom_range(99) < 5) drive_req(rand_item(CMD_SAVE));
          else drive_req(rand_item(CMD_NEXT));
        end
      end else begin
        read_sessions(70);
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("disk_sector_interleave_sequencer test passed");
    end else begin
      $display("disk_sector_interleave_sequencer test failed");
    end
    $finish;
  end

endmodule
